// ----- design/ttu_pkg.sv -----
// ----------------------------------------------------------------------------
// ttu_pkg
// Shared types, constants and functions for the text to unsigned 64-bit parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ttu_pkg;

  localparam int OFFSET_WIDTH = 16;
  localparam int VALUE_WIDTH  = 64;
  localparam int END_WIDTH    = 16;
  localparam int BASE_WIDTH   = 6;
  localparam int DIGIT_WIDTH  = 7;

  localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = {OFFSET_WIDTH{1'b1}};
  localparam logic [BASE_WIDTH-1:0]   RADIX_RESET = 6'd10;
  localparam logic [BASE_WIDTH-1:0]   BASE_AUTO   = 6'd0;
  localparam logic [BASE_WIDTH-1:0]   BASE_OCT    = 6'd8;
  localparam logic [BASE_WIDTH-1:0]   BASE_DEC    = 6'd10;
  localparam logic [BASE_WIDTH-1:0]   BASE_HEX    = 6'd16;
  localparam logic [DIGIT_WIDTH-1:0]  NOT_DIGIT   = 7'd99;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  typedef enum logic [5:0] {
    PH_DONE   = 6'b000001,
    PH_WS     = 6'b000010,
    PH_START  = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_PREFIX = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    phase_t                  phase;
    logic [BASE_WIDTH-1:0]   base;
    logic                    negative;
    logic [VALUE_WIDTH-1:0]  acc;
    logic                    overflowed;
    logic [OFFSET_WIDTH-1:0] position;
    logic                    digit_seen;
  } parse_state_t;

  typedef struct packed {
    logic                   no_conversion;
    logic                   range_error;
    logic [END_WIDTH-1:0]   end_offset;
    logic [VALUE_WIDTH-1:0] value;
  } parse_result_t;

  function automatic logic [DIGIT_WIDTH-1:0] digit_value(input logic [7:0] c);
    logic [DIGIT_WIDTH-1:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = DIGIT_WIDTH'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      d = DIGIT_WIDTH'(c - CH_LO_A) + 7'd10;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      d = DIGIT_WIDTH'(c - CH_UP_A) + 7'd10;
    end else begin
      d = NOT_DIGIT;
    end
    return d;
  endfunction

  function automatic logic [END_WIDTH-1:0] end_of(input logic [OFFSET_WIDTH-1:0] pos);
    logic [31:0] wide;
    wide = 32'(pos);
    return wide[END_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- design/text_to_u64_parser.sv -----
// ----------------------------------------------------------------------------
// text_to_u64_parser
// Streams the characters of a string and returns its unsigned 64-bit value.
// ----------------------------------------------------------------------------
// path: the result of a string passes the input register, then the result
//   register, after its terminating character is accepted
// throughput: 1 character per cycle while the output is not stalled, set by the
//   combinational 64 by 6 multiply-add with carry detect in the step logic
// reset: synchronous, active low; radix returns to 10 and the parser waits
//   for a character marked first
`default_nettype none

module text_to_u64_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,   // radix
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] ch
  input  wire logic        in_tuser,      // [0] first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,     // [63:0] value, [79:64] end_offset
  output logic [1:0]       out_tuser      // [0] range_error, [1] no_conversion
);
  import ttu_pkg::*;

  logic [BASE_WIDTH-1:0] radix_r;
  logic                  in_valid_r;
  logic [7:0]            in_ch_r;
  logic                  in_first_r;
  parse_state_t          state_r;
  parse_state_t          state_nxt;
  parse_result_t         res_nxt;
  parse_result_t         res_r;
  logic                  res_gen;
  logic                  out_valid_r;
  logic                  proc_fire;

  ttu_step u_step (
    .ch        (in_ch_r),
    .first     (in_first_r),
    .radix     (radix_r),
    .cur       (state_r),
    .nxt       (state_nxt),
    .res       (res_nxt),
    .res_valid (res_gen)
  );

  // a request without a result never waits on the output side
  assign proc_fire = in_valid_r && (!res_gen || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r    <= in_tdata;
      in_first_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_DONE, base: '0, negative: 1'b0, acc: '0,
                   overflowed: 1'b0, position: '0, digit_seen: 1'b0};
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && res_gen) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_gen) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.end_offset, res_r.value};
  assign out_tuser  = {res_r.no_conversion, res_r.range_error};

endmodule

`default_nettype wire

// ----- design/ttu_step.sv -----
// ----------------------------------------------------------------------------
// ttu_step
// One character step of the parser: next state and optional result.
// ----------------------------------------------------------------------------
`default_nettype none

module ttu_step (
  input  wire logic [7:0]             ch,
  input  wire logic                   first,
  input  wire logic [5:0]             radix,
  input  wire ttu_pkg::parse_state_t  cur,
  output ttu_pkg::parse_state_t       nxt,
  output ttu_pkg::parse_result_t      res,
  output logic                        res_valid
);
  import ttu_pkg::*;

  logic [OFFSET_WIDTH-1:0] pos_base;
  logic [OFFSET_WIDTH-1:0] pos_inc;
  logic [DIGIT_WIDTH-1:0]  dval;
  logic                    is_ws;

  assign pos_base = first ? '0 : cur.position;
  assign pos_inc  = (pos_base == OFF_MAX) ? pos_base : pos_base + OFFSET_WIDTH'(1);
  assign dval     = digit_value(ch);
  assign is_ws    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);

  always_comb begin
    logic                     do_start;
    logic                     do_digit;
    logic [VALUE_WIDTH+BASE_WIDTH-1:0] prod;
    nxt       = cur;
    res       = '0;
    res_valid = 1'b0;
    do_start  = 1'b0;
    do_digit  = 1'b0;
    prod      = '0;

    if (first) begin
      nxt.phase      = PH_WS;
      nxt.base       = radix;
      nxt.negative   = 1'b0;
      nxt.acc        = '0;
      nxt.overflowed = 1'b0;
      nxt.position   = '0;
      nxt.digit_seen = 1'b0;
    end

    case (nxt.phase)
      PH_WS: begin
        if (is_ws) begin
          nxt.position = pos_inc;
        end else if (ch == CH_MINUS || ch == CH_PLUS) begin
          nxt.negative = (ch == CH_MINUS);
          nxt.position = pos_inc;
          nxt.phase    = PH_START;
        end else begin
          do_start = 1'b1;
        end
      end
      PH_START: begin
        do_start = 1'b1;
      end
      PH_ZERO: begin
        if (ch == CH_LO_X || ch == CH_UP_X) begin
          nxt.base       = BASE_HEX;
          nxt.digit_seen = 1'b0;
          nxt.position   = pos_inc;
          nxt.phase      = PH_PREFIX;
        end else begin
          if (nxt.base == BASE_AUTO) nxt.base = BASE_OCT;
          nxt.phase = PH_DIGITS;
          do_digit  = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        nxt.phase = PH_DIGITS;
        do_digit  = 1'b1;
      end
      default: begin
      end
    endcase

    // leading zero may open a 0x prefix
    if (do_start) begin
      if ((nxt.base == BASE_AUTO || nxt.base == BASE_HEX) && ch == CH_ZERO) begin
        nxt.acc        = '0;
        nxt.digit_seen = 1'b1;
        nxt.position   = pos_inc;
        nxt.phase      = PH_ZERO;
      end else begin
        if (nxt.base == BASE_AUTO) nxt.base = BASE_DEC;
        nxt.phase = PH_DIGITS;
        do_digit  = 1'b1;
      end
    end

    if (do_digit) begin
      if (nxt.base != BASE_AUTO && dval < DIGIT_WIDTH'(nxt.base)) begin
        prod = (VALUE_WIDTH+BASE_WIDTH)'(nxt.acc) * (VALUE_WIDTH+BASE_WIDTH)'(nxt.base)
             + (VALUE_WIDTH+BASE_WIDTH)'(dval);
        if (!nxt.overflowed) begin
          // carry out of 64 bits means the value no longer fits
          if (prod[VALUE_WIDTH+BASE_WIDTH-1:VALUE_WIDTH] != '0) begin
            nxt.overflowed = 1'b1;
          end else begin
            nxt.acc = prod[VALUE_WIDTH-1:0];
          end
        end
        nxt.digit_seen = 1'b1;
        nxt.position   = pos_inc;
      end else begin
        res_valid = 1'b1;
        if (!nxt.digit_seen) begin
          res.no_conversion = 1'b1;
        end else begin
          res.value       = nxt.overflowed ? '1 :
                            (nxt.negative ? (VALUE_WIDTH'(0) - nxt.acc) : nxt.acc);
          res.end_offset  = end_of(nxt.position);
          res.range_error = nxt.overflowed;
        end
        nxt.phase = PH_DONE;
      end
    end
  end

endmodule

`default_nettype wire

// ----- bench/text_to_u64_parser_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_u64_parser_checker
// Watches the character, result and radix ports of the parser, predicts the
// result of every string from the accepted characters and compares each
// accepted result, in order, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module text_to_u64_parser_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [5:0]  cfg_wr_data,   // radix
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] ch
  input  wire logic        in_tuser,      // [0] first
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [79:0] out_tdata,     // [63:0] value, [79:64] end_offset
  input  wire logic [1:0]  out_tuser,     // [0] range_error, [1] no_conversion
  output int               failures,
  output int               pending,
  output int               results_seen
);
  import ttu_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // predicted parser state
  logic [BASE_WIDTH-1:0]   radix_q;
  phase_t                  ph;
  logic [BASE_WIDTH-1:0]   base_q;
  logic                    neg_q;
  logic [VALUE_WIDTH-1:0]  acc_q;
  logic                    ovf_q;
  logic [OFFSET_WIDTH-1:0] pos_q;
  logic                    seen_q;

  parse_result_t expected_q[$];
  int            fail_cnt = 0;
  int            result_cnt = 0;

  function automatic logic [DIGIT_WIDTH-1:0] char_digit(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return DIGIT_WIDTH'(c - CH_ZERO);
    if (c >= CH_LO_A && c <= CH_LO_Z) return DIGIT_WIDTH'(c - CH_LO_A + 8'd10);
    if (c >= CH_UP_A && c <= CH_UP_Z) return DIGIT_WIDTH'(c - CH_UP_A + 8'd10);
    return NOT_DIGIT;
  endfunction

  task automatic bump_pos();
    if (pos_q != OFF_MAX) pos_q = pos_q + OFFSET_WIDTH'(1);
  endtask

  task automatic clear_model();
    radix_q = RADIX_RESET;
    ph      = PH_DONE;
    base_q  = '0;
    neg_q   = 1'b0;
    acc_q   = '0;
    ovf_q   = 1'b0;
    pos_q   = '0;
    seen_q  = 1'b0;
    expected_q.delete();
  endtask

  // a digit of the active base extends the number, anything else ends it
  task automatic take_digit(input logic [7:0] c);
    logic [DIGIT_WIDTH-1:0] d;
    logic [VALUE_WIDTH-1:0] cutoff;
    logic [VALUE_WIDTH-1:0] cutlim;
    parse_result_t          r;
    d = char_digit(c);
    if (base_q != '0 && d < base_q) begin
      if (!ovf_q) begin
        cutoff = {VALUE_WIDTH{1'b1}} / VALUE_WIDTH'(base_q);
        cutlim = {VALUE_WIDTH{1'b1}} % VALUE_WIDTH'(base_q);
        if (acc_q > cutoff || (acc_q == cutoff && VALUE_WIDTH'(d) > cutlim)) begin
          ovf_q = 1'b1;
        end else begin
          acc_q = acc_q * VALUE_WIDTH'(base_q) + VALUE_WIDTH'(d);
        end
      end
      seen_q = 1'b1;
      bump_pos();
    end else begin
      r = '0;
      if (!seen_q) begin
        r.no_conversion = 1'b1;
      end else begin
        r.value       = ovf_q ? {VALUE_WIDTH{1'b1}} : (neg_q ? -acc_q : acc_q);
        r.end_offset  = END_WIDTH'(pos_q);
        r.range_error = ovf_q;
      end
      expected_q.push_back(r);
      ph = PH_DONE;
    end
  endtask

  task automatic start_number(input logic [7:0] c);
    if ((base_q == BASE_AUTO || base_q == BASE_HEX) && c == CH_ZERO) begin
      acc_q  = '0;
      seen_q = 1'b1;
      bump_pos();
      ph = PH_ZERO;
    end else begin
      if (base_q == BASE_AUTO) base_q = BASE_DEC;
      ph = PH_DIGITS;
      take_digit(c);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic is_first);
    if (is_first) begin
      ph     = PH_WS;
      base_q = radix_q;
      neg_q  = 1'b0;
      acc_q  = '0;
      ovf_q  = 1'b0;
      pos_q  = '0;
      seen_q = 1'b0;
    end
    case (ph)
      PH_WS: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
          bump_pos();
        end else if (c == CH_MINUS || c == CH_PLUS) begin
          neg_q = (c == CH_MINUS);
          bump_pos();
          ph = PH_START;
        end else begin
          start_number(c);
        end
      end
      PH_START: start_number(c);
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          // hex prefix: the leading zero no longer counts as a digit
          base_q = BASE_HEX;
          seen_q = 1'b0;
          bump_pos();
          ph = PH_PREFIX;
        end else begin
          if (base_q == BASE_AUTO) base_q = BASE_OCT;
          ph = PH_DIGITS;
          take_digit(c);
        end
      end
      PH_PREFIX, PH_DIGITS: take_digit(c);
      default: ;
    endcase
  endtask

  task automatic check_result(input parse_result_t got);
    parse_result_t want;
    result_cnt++;
    if (expected_q.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_LIMIT) begin
        $display("unexpected result: value %h end %0d range %0b noconv %0b",
                 got.value, got.end_offset, got.range_error, got.no_conversion);
      end
    end else begin
      want = expected_q.pop_front();
      if (got.value != want.value || got.end_offset != want.end_offset ||
          got.range_error != want.range_error ||
          got.no_conversion != want.no_conversion) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_LIMIT) begin
          $display("mismatch at result %0d: value exp %h got %h", result_cnt,
                   want.value, got.value);
          $display("  end exp %0d got %0d, range exp %0b got %0b, noconv exp %0b got %0b",
                   want.end_offset, got.end_offset, want.range_error, got.range_error,
                   want.no_conversion, got.no_conversion);
        end
      end
    end
  endtask

  initial clear_model();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
    end else begin
      if (cfg_wr_en) radix_q = cfg_wr_data;
      if (in_tvalid && in_tready) parse_char(in_tdata, in_tuser);
      if (out_tvalid && out_tready) check_result({out_tuser, out_tdata});
    end
    failures     <= fail_cnt;
    pending      <= expected_q.size();
    results_seen <= result_cnt;
  end

endmodule

// ----- bench/text_to_u64_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_to_u64_parser_tb
// Streams directed and random strings into the parser under several radix
// settings and idle patterns; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module text_to_u64_parser_tb;
  import ttu_pkg::*;

  localparam int CYCLE_LIMIT   = 600_000;
  localparam int SEGMENT_ITEMS = 25;
  localparam int SETTLE_CYCLES = 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [5:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [1:0]  out_tuser;

  int failures;
  int pending;
  int results_seen;

  int send_idle = 0;
  int recv_stall = 0;
  int cycle_count = 0;
  int strings_sent = 0;

  text_to_u64_parser dut (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  text_to_u64_parser_checker parse_monitor (
    .clk, .rst_n, .cfg_wr_en, .cfg_wr_data,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .failures, .pending, .results_seen
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] c, input logic is_first);
    if (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= is_first;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text(input string s, input logic term);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    if (term) send_char(8'h00, s.len() == 0);
    strings_sent++;
  endtask

  task automatic send_repeat(input logic [7:0] c, input int n);
    repeat (n) send_char(c, 1'b0);
  endtask

  // stop the stream and let every outstanding result come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radix(input logic [5:0] r);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= r;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] digit_char(input int v, input bit upper);
    if (v < 10) return CH_ZERO + 8'(v);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(v - 10);
  endfunction

  // mostly well-formed numbers with random content, some noise and
  // strings left open so the next first mark drops them
  task automatic send_random_string(input logic [5:0] r, output int sent);
    logic [7:0] s[$];
    int n;
    int v;
    int eff;
    int lim;
    int pick;
    eff = r;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) s.push_back(8'($urandom_range(255)));
    end else begin
      n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (n) begin
        v = $urandom_range(0, 5);
        s.push_back(v == 5 ? CH_SPACE : CH_TAB + 8'(v));
      end
      pick = $urandom_range(2);
      if (pick == 1) s.push_back(CH_PLUS);
      if (pick == 2) s.push_back(CH_MINUS);
      if (r == BASE_AUTO) begin
        pick = $urandom_range(2);
        if (pick == 0) begin
          s.push_back(CH_ZERO);
          s.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
          eff = BASE_HEX;
        end else if (pick == 1) begin
          s.push_back(CH_ZERO);
          eff = BASE_OCT;
        end else begin
          eff = BASE_DEC;
        end
      end else if (r == BASE_HEX && $urandom_range(1)) begin
        s.push_back(CH_ZERO);
        s.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
      end
      lim = (eff > 36) ? 36 : eff;
      n = ($urandom_range(4) == 0) ? $urandom_range(20, 70) : $urandom_range(0, 20);
      repeat (n) s.push_back(digit_char($urandom_range(0, lim - 1), $urandom_range(1)));
      pick = $urandom_range(9);
      if (pick < 6) s.push_back(8'h00);
      else if (pick < 9) s.push_back(8'($urandom_range(255)));
    end
    if (s.size() == 0) s.push_back(8'h00);
    sent = s.size();
    // trailing characters after the end are ignored by the parser
    if ($urandom_range(3) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) s.push_back(8'($urandom_range(255)));
    end
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == 0);
    strings_sent++;
  endtask

  int unsigned idle_plan[4]  = '{0, 82, 0, 23};
  int unsigned stall_plan[4] = '{0, 0, 82, 23};
  logic [5:0]  radix_plan[12] = '{6'd0, 6'd10, 6'd16, 6'd2, 6'd36, 6'd1,
                                  6'd8, 6'd0, 6'd63, 6'd37, 6'd16, 6'd0};

  initial begin
    int budget;
    int sent;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings, reset radix of ten first
    send_char("7", 1'b0);                         // stray character, no string open
    send_text("\011\012\013\014\015 +42", 1'b1);
    send_text("-1", 1'b1);
    send_text("18446744073709551615", 1'b1);
    send_text("18446744073709551616", 1'b1);
    send_text("-99999999999999999999x", 1'b1);
    send_text("abc", 1'b1);
    send_text("", 1'b1);
    send_text("12", 1'b0);                        // no terminator, dropped
    send_text("34", 1'b1);
    // radix written while a string is open applies to the next string only
    send_char("7", 1'b1);
    write_radix(BASE_HEX);
    send_char("f", 1'b0);
    send_char(8'h00, 1'b0);
    send_text("ff", 1'b1);
    send_text("0x1F", 1'b1);
    send_text("0X", 1'b1);
    send_text("0xg", 1'b1);
    send_text("0", 1'b1);
    write_radix(BASE_AUTO);
    send_text("0x7fz", 1'b1);
    send_text("0777", 1'b1);
    send_text("-0x", 1'b1);
    send_text("089", 1'b1);
    send_text(" 123", 1'b1);
    write_radix(6'd1);
    send_text("000", 1'b1);
    send_text("1", 1'b1);
    write_radix(6'd36);
    send_text("zZ", 1'b1);
    write_radix(6'd63);
    send_text("Zz9!", 1'b1);
    write_radix(6'd2);
    send_char("1", 1'b1);
    send_repeat("1", 64);
    send_char(8'h00, 1'b0);
    strings_sent++;

    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle  = idle_plan[p];
      recv_stall = stall_plan[p];
      for (int k = 0; k < 3; k++) begin
        write_radix(radix_plan[p * 3 + k]);
        budget = 0;
        while (budget < SEGMENT_ITEMS) begin
          send_random_string(radix_plan[p * 3 + k], sent);
          budget += sent;
        end
      end
    end

    drain();
    $display("sent %0d strings across radix 0 to 63 under four idle patterns", strings_sent);
    $display("checked %0d results, %0d mismatches", results_seen, failures);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
